[rtl/dda_pkg.sv]
package dda_pkg;

   // Default geometry of the segment coordinates and of the fixed-point increments.
   localparam int COORD_BITS_DEFAULT = 6;
   localparam int FRAC_BITS_DEFAULT  = 16;

   // Width of the centre registers and of the screen pixel coordinates.
   localparam int CFG_BITS = 10;
   localparam int PIX_BITS = 12;

   // Register file addressing.
   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CENTRE_X = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CENTRE_Y = 2'd1;

   localparam logic [CFG_BITS-1:0] CENTRE_X_RESET = 10'd320;
   localparam logic [CFG_BITS-1:0] CENTRE_Y_RESET = 10'd240;

endpackage

[rtl/dda_line_rasterizer_top.sv]
// Line segment rasteriser using the DDA method.
// Request channel (req_): one word per segment, start and end points given
// relative to the screen origin, y pointing upwards.
// Response channel (rsp_): one word per pixel, start pixel first, endpoint last
// with rsp_last_pixel set; a segment of length n gives n + 1 words.
// Register channel (csr_): index 0 is the origin column, index 1 the origin row;
// other indices are ignored. It is always ready and should be written only
// while no segment is in flight.
// Sequence: a segment that is taken is registered, then the shared restoring
// divider works out the x and then the y increment, one quotient bit per
// cycle. Pixels then leave at one per cycle while the receiver is ready;
// a zero-length segment skips the divider.
// req_ready is high only while the sequencer is idle, so a new segment may be
// taken while the last pixel of the previous one still waits in the output
// register. When the receiver stalls, the pixel is held and the stepping
// pauses. Reset, synchronous and active high, restores the origin to (320, 240),
// empties the output register and returns the sequencer to idle.
module dda_line_rasterizer_top #(
   parameter int COORD_BITS = dda_pkg::COORD_BITS_DEFAULT,
   parameter int FRAC_BITS  = dda_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [COORD_BITS-1:0]          req_start_x,
   input  logic signed [COORD_BITS-1:0]          req_start_y,
   input  logic signed [COORD_BITS-1:0]          req_end_x,
   input  logic signed [COORD_BITS-1:0]          req_end_y,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [dda_pkg::PIX_BITS-1:0]   rsp_pixel_col,
   output logic signed [dda_pkg::PIX_BITS-1:0]   rsp_pixel_row,
   output logic                                  rsp_last_pixel,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [dda_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [dda_pkg::CFG_BITS-1:0]          csr_wdata
);

   localparam int MAG_BITS  = COORD_BITS;
   localparam int ACC_BITS  = COORD_BITS + FRAC_BITS + 2;
   localparam int ACC_EXT   = ACC_BITS - COORD_BITS - FRAC_BITS;
   localparam int QUO_EXT   = ACC_BITS - FRAC_BITS - 1;
   localparam int SUM_BITS  = dda_pkg::CFG_BITS + FRAC_BITS + 2;
   localparam int SUM_EXT   = SUM_BITS - ACC_BITS;
   localparam int CNT_BITS  = $clog2(FRAC_BITS + 1);
   localparam int PIX_BITS  = dda_pkg::PIX_BITS;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIVX = 2'd1;
   localparam logic [1:0] ST_DIVY = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   logic [1:0]                   state_ff, state_in;
   logic [dda_pkg::CFG_BITS-1:0] centre_x_ff, centre_x_in;
   logic [dda_pkg::CFG_BITS-1:0] centre_y_ff, centre_y_in;
   logic signed [ACC_BITS-1:0]   x_accum_ff, x_accum_in;
   logic signed [ACC_BITS-1:0]   y_accum_ff, y_accum_in;
   logic signed [ACC_BITS-1:0]   x_step_ff, x_step_in;
   logic signed [ACC_BITS-1:0]   y_step_ff, y_step_in;
   logic [MAG_BITS-1:0]          steps_left_ff, steps_left_in;
   logic [MAG_BITS-1:0]          steps_ff, steps_in;
   logic [MAG_BITS-1:0]          mag_x_ff, mag_x_in;
   logic [MAG_BITS-1:0]          mag_y_ff, mag_y_in;
   logic                         neg_x_ff, neg_x_in;
   logic                         neg_y_ff, neg_y_in;
   logic signed [COORD_BITS-1:0] end_x_ff, end_x_in;
   logic signed [COORD_BITS-1:0] end_y_ff, end_y_in;
   logic [MAG_BITS:0]            div_rem_ff, div_rem_in;
   logic [FRAC_BITS:0]           div_quo_ff, div_quo_in;
   logic [CNT_BITS-1:0]          div_cnt_ff, div_cnt_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [PIX_BITS-1:0]   rsp_pixel_col_ff, rsp_pixel_col_in;
   logic signed [PIX_BITS-1:0]   rsp_pixel_row_ff, rsp_pixel_row_in;
   logic                         rsp_last_pixel_ff, rsp_last_pixel_in;

   // Set-up of a new segment.
   logic signed [COORD_BITS:0]   delta_x, delta_y;
   logic [COORD_BITS:0]          abs_x, abs_y;
   logic [MAG_BITS-1:0]          new_mag_x, new_mag_y, new_steps;
   logic                         req_take;

   // Shared divider.
   logic [MAG_BITS-1:0]          cur_mag;
   logic                         cur_neg;
   logic [FRAC_BITS:0]           low_bits;
   logic [MAG_BITS:0]            trial;
   logic [MAG_BITS:0]            trial_diff;
   logic                         trial_ge;
   logic [FRAC_BITS:0]           quo_next;
   logic signed [ACC_BITS-1:0]   step_pos;
   logic signed [ACC_BITS-1:0]   step_val;
   logic                         div_done;

   // Pixel mapping.
   logic signed [SUM_BITS-1:0]   col_sum, row_sum;
   logic signed [PIX_BITS-1:0]   pix_col, pix_row;
   logic                         col_adj, row_adj;
   logic                         out_load;

   assign req_ready      = (state_ff == ST_IDLE);
   assign req_take       = req_valid && req_ready;
   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_col  = rsp_pixel_col_ff;
   assign rsp_pixel_row  = rsp_pixel_row_ff;
   assign rsp_last_pixel = rsp_last_pixel_ff;

   assign delta_x   = {req_end_x[COORD_BITS-1], req_end_x}
                    - {req_start_x[COORD_BITS-1], req_start_x};
   assign delta_y   = {req_end_y[COORD_BITS-1], req_end_y}
                    - {req_start_y[COORD_BITS-1], req_start_y};
   assign abs_x     = delta_x[COORD_BITS] ? -delta_x : delta_x;
   assign abs_y     = delta_y[COORD_BITS] ? -delta_y : delta_y;
   assign new_mag_x = abs_x[MAG_BITS-1:0];
   assign new_mag_y = abs_y[MAG_BITS-1:0];
   assign new_steps = (new_mag_x > new_mag_y) ? new_mag_x : new_mag_y;

   // The dividend is {magnitude, steps / 2} with FRAC_BITS bits below the
   // point. The remainder starts with all but the last magnitude bit, so the
   // quotient comes out in FRAC_BITS + 1 iterations.
   assign cur_mag    = (state_ff == ST_DIVY) ? mag_y_ff : mag_x_ff;
   assign cur_neg    = (state_ff == ST_DIVY) ? neg_y_ff : neg_x_ff;
   assign low_bits   = {cur_mag[0], FRAC_BITS'(steps_ff >> 1)};
   assign trial      = {div_rem_ff[MAG_BITS-1:0], low_bits[div_cnt_ff]};
   assign trial_ge   = (trial >= {1'b0, steps_ff});
   assign trial_diff = trial - {1'b0, steps_ff};
   assign quo_next   = {div_quo_ff[FRAC_BITS-1:0], trial_ge};
   assign div_done   = (div_cnt_ff == '0);
   assign step_pos   = $signed({{QUO_EXT{1'b0}}, quo_next});
   assign step_val   = cur_neg ? -step_pos : step_pos;

   // Screen position with truncation toward zero on the signed sum.
   assign col_sum = $signed({2'b00, centre_x_ff, {FRAC_BITS{1'b0}}})
                  + $signed({{SUM_EXT{x_accum_ff[ACC_BITS-1]}}, x_accum_ff});
   assign row_sum = $signed({2'b00, centre_y_ff, {FRAC_BITS{1'b0}}})
                  - $signed({{SUM_EXT{y_accum_ff[ACC_BITS-1]}}, y_accum_ff});
   assign col_adj = col_sum[SUM_BITS-1] && (|col_sum[FRAC_BITS-1:0]);
   assign row_adj = row_sum[SUM_BITS-1] && (|row_sum[FRAC_BITS-1:0]);
   assign pix_col = col_sum[FRAC_BITS +: PIX_BITS] + PIX_BITS'(col_adj);
   assign pix_row = row_sum[FRAC_BITS +: PIX_BITS] + PIX_BITS'(row_adj);

   assign out_load = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in          = state_ff;
      centre_x_in       = centre_x_ff;
      centre_y_in       = centre_y_ff;
      x_accum_in        = x_accum_ff;
      y_accum_in        = y_accum_ff;
      x_step_in         = x_step_ff;
      y_step_in         = y_step_ff;
      steps_left_in     = steps_left_ff;
      steps_in          = steps_ff;
      mag_x_in          = mag_x_ff;
      mag_y_in          = mag_y_ff;
      neg_x_in          = neg_x_ff;
      neg_y_in          = neg_y_ff;
      end_x_in          = end_x_ff;
      end_y_in          = end_y_ff;
      div_rem_in        = div_rem_ff;
      div_quo_in        = div_quo_ff;
      div_cnt_in        = div_cnt_ff;
      rsp_valid_in      = rsp_valid_ff;
      rsp_pixel_col_in  = rsp_pixel_col_ff;
      rsp_pixel_row_in  = rsp_pixel_row_ff;
      rsp_last_pixel_in = rsp_last_pixel_ff;

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            dda_pkg::CSR_CENTRE_X: centre_x_in = csr_wdata;
            dda_pkg::CSR_CENTRE_Y: centre_y_in = csr_wdata;
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               x_accum_in    = $signed({{ACC_EXT{req_start_x[COORD_BITS-1]}}, req_start_x,
                                        {FRAC_BITS{1'b0}}});
               y_accum_in    = $signed({{ACC_EXT{req_start_y[COORD_BITS-1]}}, req_start_y,
                                        {FRAC_BITS{1'b0}}});
               end_x_in      = req_end_x;
               end_y_in      = req_end_y;
               mag_x_in      = new_mag_x;
               mag_y_in      = new_mag_y;
               neg_x_in      = delta_x[COORD_BITS];
               neg_y_in      = delta_y[COORD_BITS];
               steps_in      = new_steps;
               steps_left_in = new_steps;
               div_rem_in    = (MAG_BITS + 1)'(new_mag_x >> 1);
               div_cnt_in    = CNT_BITS'(FRAC_BITS);
               state_in      = (new_steps == '0) ? ST_EMIT : ST_DIVX;
            end
         end
         ST_DIVX, ST_DIVY: begin
            div_rem_in = trial_ge ? trial_diff : trial;
            div_quo_in = quo_next;
            div_cnt_in = div_cnt_ff - 1'b1;
            if (div_done) begin
               if (state_ff == ST_DIVX) begin
                  x_step_in  = step_val;
                  div_rem_in = (MAG_BITS + 1)'(mag_y_ff >> 1);
                  div_cnt_in = CNT_BITS'(FRAC_BITS);
                  state_in   = ST_DIVY;
               end else begin
                  y_step_in  = step_val;
                  state_in   = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (out_load) begin
               rsp_valid_in      = 1'b1;
               rsp_pixel_col_in  = pix_col;
               rsp_pixel_row_in  = pix_row;
               rsp_last_pixel_in = (steps_left_ff == '0);
               if (steps_left_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  steps_left_in = steps_left_ff - 1'b1;
                  // The final pixel takes the exact endpoint, so rounding in
                  // the increments cannot pull it away.
                  if (steps_left_ff == MAG_BITS'(1)) begin
                     x_accum_in = $signed({{ACC_EXT{end_x_ff[COORD_BITS-1]}}, end_x_ff,
                                           {FRAC_BITS{1'b0}}});
                     y_accum_in = $signed({{ACC_EXT{end_y_ff[COORD_BITS-1]}}, end_y_ff,
                                           {FRAC_BITS{1'b0}}});
                  end else begin
                     x_accum_in = x_accum_ff + x_step_ff;
                     y_accum_in = y_accum_ff + y_step_ff;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         centre_x_ff  <= dda_pkg::CENTRE_X_RESET;
         centre_y_ff  <= dda_pkg::CENTRE_Y_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         centre_x_ff  <= centre_x_in;
         centre_y_ff  <= centre_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_accum_ff        <= x_accum_in;
      y_accum_ff        <= y_accum_in;
      x_step_ff         <= x_step_in;
      y_step_ff         <= y_step_in;
      steps_left_ff     <= steps_left_in;
      steps_ff          <= steps_in;
      mag_x_ff          <= mag_x_in;
      mag_y_ff          <= mag_y_in;
      neg_x_ff          <= neg_x_in;
      neg_y_ff          <= neg_y_in;
      end_x_ff          <= end_x_in;
      end_y_ff          <= end_y_in;
      div_rem_ff        <= div_rem_in;
      div_quo_ff        <= div_quo_in;
      div_cnt_ff        <= div_cnt_in;
      rsp_pixel_col_ff  <= rsp_pixel_col_in;
      rsp_pixel_row_ff  <= rsp_pixel_row_in;
      rsp_last_pixel_ff <= rsp_last_pixel_in;
   end

`ifndef SYNTHESIS
   // A zero-length segment goes straight to its single pixel.
   a_zero_length: assert property (@(posedge clock) disable iff (reset)
      (req_take && (req_start_x == req_end_x) && (req_start_y == req_end_y))
      |=> (state_ff == ST_EMIT && steps_left_ff == '0))
      else $error("zero-length segment did not skip the divider");

   // The partial remainder of the divider always stays below the divisor.
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVX || state_ff == ST_DIVY) |-> (div_rem_ff < {1'b0, steps_ff}))
      else $error("divider remainder out of range");

   // Loading the final pixel ends the segment with a flagged word.
   a_last_word: assert property (@(posedge clock) disable iff (reset)
      (out_load && steps_left_ff == '0)
      |=> (state_ff == ST_IDLE && rsp_valid_ff && rsp_last_pixel_ff))
      else $error("final pixel not flagged or sequencer not idle");

   // Every pixel other than the last uses up exactly one step.
   a_step_count: assert property (@(posedge clock) disable iff (reset)
      (out_load && steps_left_ff != '0)
      |=> (steps_left_ff == $past(steps_left_ff) - 1'b1 && !rsp_last_pixel_ff))
      else $error("step count did not advance by one");
`endif

endmodule
